@@ src/wvr_pkg.sv @@
package wvr_pkg;

  localparam int unsigned Words    = 32;
  localparam int unsigned WordBits = 32;
  localparam int unsigned BitSelW  = $clog2(WordBits);
  localparam int unsigned AddrW    = $clog2(Words);
  localparam int unsigned CountW   = $clog2(Words + 1);
  localparam int unsigned VecBits  = Words * WordBits;
  localparam int unsigned RotW     = $clog2(VecBits);
  localparam int unsigned AmountW  = 11;
  localparam int unsigned ExtW     = (RotW > AmountW) ? RotW : AmountW;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [WordBits-1:0] wr_data;
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
  } mem_req_t;

endpackage

@@ src/wvr_store.sv @@
module wvr_store
  import wvr_pkg::*;
(
  input  logic                clk_i,
  input  mem_req_t            req_i,
  output logic [WordBits-1:0] rd_data_o
);

  logic [WordBits-1:0] mem_q [Words];
  logic [WordBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/wide_vector_bit_rotate.sv @@
// Channel  | Direction | Handshake                | Payload
// input    | in        | in_valid_i / in_ready_o   | word_value_i
// output   | out       | out_valid_o / out_ready_i | rotated_word_o, last_word_o
// config   | in        | cfg_we_i                  | cfg_wdata_i
//
// One input item is taken per cycle while a vector is loading.
// After the last word, Words + 1 reads of the store produce Words result
// items at one per cycle when the output is not stalled.
// Reset clears the control state and the rotation amount; the store is not cleared.
// A stalled output holds its item and pauses the store reads behind it.
module wide_vector_bit_rotate
  import wvr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic signed [AmountW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [WordBits-1:0]        word_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [WordBits-1:0]        rotated_word_o,
  output logic                       last_word_o
);

  state_e state_q, state_d;

  logic signed [AmountW-1:0] amount_q;
  logic [AddrW-1:0]          load_cnt_q;
  logic [AddrW-1:0]          raddr_q;
  logic [CountW-1:0]         rcnt_q;
  logic [AddrW-1:0]          ocnt_q;
  logic [BitSelW-1:0]        bs_q;
  logic                      dv_q;
  logic                      first_q;
  logic                      ov_q;
  logic [WordBits-1:0]       prev_q;
  logic [WordBits-1:0]       out_data_q;
  logic                      out_last_q;

  logic [ExtW-1:0]     amount_ext;
  logic [RotW-1:0]     rot;
  logic [AddrW-1:0]    start_addr;
  logic [WordBits-1:0] rd_data;
  logic [WordBits-1:0] rot_word;
  logic                in_fire;
  logic                load_done;
  logic                consume;
  logic                produce;
  logic                rd_en;
  logic                emit_done;
  mem_req_t            mem_req;

  assign amount_ext = ExtW'(amount_q);
  assign rot        = amount_ext[RotW-1:0];
  assign start_addr = AddrW'(Words - 1) - rot[RotW-1:BitSelW];

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_done  = in_fire && (load_cnt_q == AddrW'(Words - 1));

  assign consume   = dv_q && (first_q || !ov_q || out_ready_i);
  assign produce   = consume && !first_q;
  assign rd_en     = (state_q == ST_EMIT) && (rcnt_q != CountW'(Words + 1))
                     && (!dv_q || consume);
  assign emit_done = produce && (ocnt_q == AddrW'(Words - 1));

  always_comb begin
    if (bs_q == '0) begin
      rot_word = rd_data;
    end else begin
      rot_word = (rd_data << bs_q) | (prev_q >> (BitSelW'(WordBits - 1) - bs_q + BitSelW'(1)));
    end
  end

  always_comb begin
    mem_req.wr_en   = in_fire;
    mem_req.wr_addr = load_cnt_q;
    mem_req.wr_data = word_value_i;
    mem_req.rd_en   = rd_en;
    mem_req.rd_addr = raddr_q;
  end

  wvr_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (load_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q   <= '0;
      load_cnt_q <= '0;
      raddr_q    <= '0;
      rcnt_q     <= '0;
      ocnt_q     <= '0;
      bs_q       <= '0;
      dv_q       <= 1'b0;
      first_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        amount_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        load_cnt_q <= load_done ? '0 : load_cnt_q + AddrW'(1);
      end
      if (load_done) begin
        raddr_q <= start_addr;
        rcnt_q  <= '0;
        ocnt_q  <= '0;
        bs_q    <= rot[BitSelW-1:0];
        first_q <= 1'b1;
      end else begin
        if (rd_en) begin
          raddr_q <= (raddr_q == AddrW'(Words - 1)) ? '0 : raddr_q + AddrW'(1);
          rcnt_q  <= rcnt_q + CountW'(1);
        end
        if (consume && first_q) begin
          first_q <= 1'b0;
        end
        if (produce) begin
          ocnt_q <= emit_done ? '0 : ocnt_q + AddrW'(1);
        end
      end
      if (rd_en) begin
        dv_q <= 1'b1;
      end else if (consume) begin
        dv_q <= 1'b0;
      end
      if (produce) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      prev_q <= rd_data;
    end
    if (produce) begin
      out_data_q <= rot_word;
      out_last_q <= (ocnt_q == AddrW'(Words - 1));
    end
  end

  assign out_valid_o    = ov_q;
  assign rotated_word_o = out_data_q;
  assign last_word_o    = out_last_q;

endmodule

@@ src/wvr_checker.sv @@
module wvr_checker
  import wvr_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [WordBits-1:0]       rotated_word_o,
  input logic                      last_word_o
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rotated_word_o)
      && $stable(last_word_o))
    else $error("result item changed while stalled");

  // The input side closes only after it has taken the last word of a vector.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input side closed without an accepted item");

  // No result item is offered right after reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered after reset");

  // While the results before the last item of a vector are being sent, no new item is taken.
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o && !in_ready_o |=> !(in_ready_o && in_valid_i)
      || out_valid_o || $past(out_ready_i))
    else $error("item taken while a vector was being sent");

endmodule

bind wide_vector_bit_rotate wvr_checker u_wvr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .rotated_word_o (rotated_word_o),
  .last_word_o    (last_word_o)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import wvr_pkg::*;

  localparam int DrainCycles  = 2 * Words + 8;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 200000;
  localparam int RandVectors  = 1;

  typedef enum {
    FILL_ONEHOT,
    FILL_ALT,
    FILL_ONES,
    FILL_ZERO,
    FILL_RAND
  } fill_e;

  typedef struct {
    bit                        wr;
    logic signed [AmountW-1:0] amount;
    fill_e                     fill;
    bit                        same;
    int                        split;
    logic signed [AmountW-1:0] split_amount;
  } vec_row_t;

  typedef struct {
    logic [WordBits-1:0] word;
    logic                last;
  } rot_word_t;

  // Rows marked same expect the vector back unchanged.
  localparam int NumRows = 5;
  vec_row_t dir_rows [NumRows] = '{
    '{1'b0,     0, FILL_ONEHOT, 1'b1, -1,    0},
    '{1'b1,     1, FILL_ONEHOT, 1'b0, -1,    0},
    '{1'b1,    -1, FILL_ALT,    1'b0, -1,    0},
    '{1'b1, -1024, FILL_RAND,   1'b1, -1,    0},
    '{1'b1,  1023, FILL_RAND,   1'b0, 16,   32}
  };

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic signed [AmountW-1:0]  cfg_wdata_i  = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic [WordBits-1:0]        word_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic [WordBits-1:0]        rotated_word_o;
  logic                       last_word_o;

  logic [WordBits-1:0]       loaded_words [Words];
  int                        words_loaded = 0;
  logic signed [AmountW-1:0] rot_amount   = '0;
  bit                        pass_through = 1'b0;
  rot_word_t                 expected_words [$];
  int                        errors       = 0;
  int                        cycle_count  = 0;
  int                        tx_idle_pct  = 18;
  int                        rx_idle_pct  = 49;
  int                        hold_req     = 0;
  int                        hold_seen    = 0;
  int                        hold_left    = 0;

  wide_vector_bit_rotate DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_value_i   (word_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rotated_word_o (rotated_word_o),
    .last_word_o    (last_word_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // A change of hold_req starts a long stall of the output, counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rot_word_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected item: rotated_word %h last_word %b", rotated_word_o, last_word_o);
        errors++;
      end else begin
        exp_item = expected_words.pop_front();
        if (rotated_word_o !== exp_item.word) begin
          $error("rotated_word: expected %h, got %h", exp_item.word, rotated_word_o);
          errors++;
        end
        if (last_word_o !== exp_item.last) begin
          $error("last_word: expected %b, got %b", exp_item.last, last_word_o);
          errors++;
        end
      end
    end
  end

  function automatic void queue_rotated_vector();
    logic [VecBits-1:0] vec;
    logic [VecBits-1:0] rot;
    int                 vec_len;
    int                 r;
    vec_len = VecBits;
    for (int i = 0; i < Words; i++) vec[i*WordBits +: WordBits] = loaded_words[i];
    r = int'(rot_amount) % vec_len;
    if (r < 0) r += vec_len;
    if (pass_through || r == 0) rot = vec;
    else rot = (vec << r) | (vec >> (vec_len - r));
    for (int i = 0; i < Words; i++) begin
      expected_words.push_back('{rot[i*WordBits +: WordBits], (i == Words - 1)});
    end
  endfunction

  function automatic logic [WordBits-1:0] fill_word(input fill_e f, input int i);
    case (f)
      FILL_ONEHOT: begin
        if (i == 0) return 32'h0000_0001;
        if (i == Words - 1) return 32'h8000_0000;
        return '0;
      end
      FILL_ALT:  return i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
      FILL_ONES: return '1;
      FILL_ZERO: return '0;
      default: begin
        case ($urandom_range(15))
          0:       return '0;
          1:       return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_word(input logic [WordBits-1:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_value_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    loaded_words[words_loaded] = w;
    words_loaded++;
    if (words_loaded == Words) begin
      words_loaded = 0;
      queue_rotated_vector();
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_amount(input logic signed [AmountW-1:0] a);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    rot_amount  = a;
  endtask

  task automatic send_vector(input fill_e f, input int split,
                             input logic signed [AmountW-1:0] split_amount);
    for (int i = 0; i < Words; i++) begin
      if (i == split) write_amount(split_amount);
      send_word(fill_word(f, i));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].wr) write_amount(dir_rows[k].amount);
      pass_through = dir_rows[k].same;
      send_vector(dir_rows[k].fill, dir_rows[k].split, dir_rows[k].split_amount);
    end
    pass_through = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 49;
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_amount(AmountW'($urandom_range(2047)));
      if (phase == 1) hold_req++;
      // During the long output stall a second vector is offered so the input stalls.
      for (int v = 0; v < RandVectors + ((phase == 1) ? 1 : 0); v++) begin
        send_vector(FILL_RAND, -1, '0);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/wvr_pkg.sv
src/wvr_store.sv
src/wide_vector_bit_rotate.sv
src/wvr_checker.sv
dv/tb.sv
